### hdl/csg_pkg.sv
// ----------------------------------------------------------------------------
// csg_pkg: shared types and constants of the centered marker stroke generator
// Holds the stroke programs, escape codes, result kinds and the types passed
// between the walker, the stroke ROM and the top level.
// ----------------------------------------------------------------------------
package csg_pkg;

	localparam int SymbolCount = 16;
	localparam int SymW        = $clog2(SymbolCount);
	localparam int EntryW      = 4;
	localparam int RomAddrW    = SymW + EntryW;
	localparam int WidthW      = 31;
	localparam int CoordW      = 32;
	// Q24.18 working coordinates, wide enough for sixteen origin shifts
	localparam int AccW        = 42;

	// Result kinds
	localparam logic [1:0] KIND_POINT = 2'd0;
	localparam logic [1:0] KIND_LIFT  = 2'd1;
	localparam logic [1:0] KIND_MOVE  = 2'd2;

	// Escape entry: first code, then second code
	localparam logic [3:0] ESC        = 4'd9;
	localparam logic [3:0] ESC_STOP   = 4'd9;
	localparam logic [3:0] ESC_LIFT   = 4'd8;
	localparam logic [3:0] ESC_REPEAT = 4'd7;
	localparam logic [3:0] ESC_T_UP   = 4'd1;
	localparam logic [3:0] ESC_T_DOWN = 4'd2;
	localparam logic [3:0] ESC_S_UP   = 4'd3;
	localparam logic [3:0] ESC_S_DOWN = 4'd4;

	// Configuration register indexes
	localparam logic [1:0] CFG_S_LOW  = 2'd0;
	localparam logic [1:0] CFG_S_HIGH = 2'd1;
	localparam logic [1:0] CFG_T_LOW  = 2'd2;
	localparam logic [1:0] CFG_T_HIGH = 2'd3;

	// Stroke programs; entry 0 sits in the top nibble
	localparam logic [63:0] STROKE_I [SymbolCount] = '{
		64'h2244_0029_0000_0000,
		64'h2234_4310_0129_0000,
		64'h2240_2900_0000_0000,
		64'h2290_4900_0000_0000,
		64'h0490_4900_0000_0000,
		64'h2242_0290_0000_0000,
		64'h2204_2900_0000_0000,
		64'h0404_9000_0000_0000,
		64'h4090_4049_0000_0000,
		64'h2202_4900_0000_0000,
		64'h2234_3343_1011_0129,
		64'h0492_2940_9049_0000,
		64'h0404_0900_0000_0000,
		64'h2290_0000_0000_0000,
		64'h2240_2942_0490_0000,
		64'h0490_0000_0000_0000
	};

	localparam logic [63:0] STROKE_J [SymbolCount] = '{
		64'h2440_0449_0000_0000,
		64'h2443_1001_3449_0000,
		64'h2411_4900_0000_0000,
		64'h0482_2900_0000_0000,
		64'h0484_0900_0000_0000,
		64'h2420_2490_0000_0000,
		64'h0422_4900_0000_0000,
		64'h0440_9000_0000_0000,
		64'h2284_4009_0000_0000,
		64'h0242_4900_0000_0000,
		64'h2334_3101_1013_4339,
		64'h0484_0804_8229_0000,
		64'h0440_0900_0000_0000,
		64'h0490_0000_0000_0000,
		64'h2411_4830_3390_0000,
		64'h2290_0000_0000_0000
	};

	// One symbol to draw
	typedef struct packed {
		logic [SymW-1:0]          sym;
		logic [WidthW-1:0]        width;
		logic signed [CoordW-1:0] pen_s;
		logic signed [CoordW-1:0] pen_t;
	} job_t;

	// Stroke ROM read request
	typedef struct packed {
		logic                en;
		logic [RomAddrW-1:0] addr;
	} rom_req_t;

endpackage

### hdl/csg_rom.sv
// ----------------------------------------------------------------------------
// csg_rom: stroke program ROM
// Synchronous, registered read; the data holds while no read is issued.
// Each word is one program entry: first code in the high nibble.
// ----------------------------------------------------------------------------
module csg_rom (
	input  logic                         clk,
	input  csg_pkg::rom_req_t            req,
	output logic [2*csg_pkg::EntryW-1:0] data
);

	logic [csg_pkg::SymW-1:0]     sym;
	logic [csg_pkg::EntryW-1:0]   entry;
	logic [2*csg_pkg::EntryW-1:0] data_q;

	assign sym   = req.addr[csg_pkg::RomAddrW-1 -: csg_pkg::SymW];
	assign entry = req.addr[csg_pkg::EntryW-1:0];

	// Registered read
	always_ff @(posedge clk) begin
		if (req.en) begin
			data_q <= {csg_pkg::STROKE_I[sym][{~entry, 2'b00} +: csg_pkg::EntryW],
			           csg_pkg::STROKE_J[sym][{~entry, 2'b00} +: csg_pkg::EntryW]};
		end
	end

	assign data = data_q;

endmodule

### hdl/csg_walker.sv
// ----------------------------------------------------------------------------
// csg_walker: stroke program sequencer
// Walks one program entry per cycle out of the stroke ROM while the output
// is not stalled, keeps the local origin in Q24.18 and loads results into the output register.
// ----------------------------------------------------------------------------
module csg_walker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  csg_pkg::job_t                       job,
	output logic                                idle,
	output csg_pkg::rom_req_t                   rom_req,
	input  logic [2*csg_pkg::EntryW-1:0]        rom_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          event_kind,
	output logic signed [csg_pkg::CoordW-1:0]   point_s,
	output logic signed [csg_pkg::CoordW-1:0]   point_t,
	output logic                                last_event
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_WALK  = 3'b010,
		ST_FINAL = 3'b100
	} state_t;

	localparam int AccW = csg_pkg::AccW;
	localparam int WW   = csg_pkg::WidthW;

	// Q24.18 to Q16.16: floor by arithmetic shift, then saturate
	function automatic logic [csg_pkg::CoordW-1:0] to_out(input logic signed [AccW-1:0] q);
		logic [AccW-3:0] r;
		r = q[AccW-1:2];
		if (!r[AccW-3] && (|r[AccW-4:csg_pkg::CoordW-1])) begin
			to_out = {1'b0, {(csg_pkg::CoordW-1){1'b1}}};
		end else if (r[AccW-3] && !(&r[AccW-4:csg_pkg::CoordW-1])) begin
			to_out = {1'b1, {(csg_pkg::CoordW-1){1'b0}}};
		end else begin
			to_out = r[csg_pkg::CoordW-1:0];
		end
	endfunction

	state_t                         state_q, state_d;
	logic [csg_pkg::SymW-1:0]       sym_q;
	logic [csg_pkg::EntryW-1:0]     k_q;
	logic [WW-1:0]                  w_q;
	logic [WW+2:0]                  w10_q;
	logic signed [AccW-1:0]         s0_q, t0_q, s0_d, t0_d;
	logic [csg_pkg::CoordW-1:0]     last_s_q, last_t_q;

	logic                           out_valid_q;
	logic [1:0]                     kind_q;
	logic [csg_pkg::CoordW-1:0]     ps_q, pt_q;
	logic                           last_q;

	logic [csg_pkg::EntryW-1:0]     ent_i, ent_j;
	logic                           esc, stop, emits, out_free, go, load;
	logic [1:0]                     kind_d;
	logic [csg_pkg::CoordW-1:0]     ps_d, pt_d;
	logic [WW+3:0]                  iw, jw;
	logic [csg_pkg::CoordW-1:0]     grid_s, grid_t;
	logic signed [AccW-1:0]         s0_init, t0_init, d10;

	assign ent_i    = rom_data[2*csg_pkg::EntryW-1 -: csg_pkg::EntryW];
	assign ent_j    = rom_data[csg_pkg::EntryW-1:0];
	assign esc      = (ent_i == csg_pkg::ESC);
	assign stop     = esc && (ent_j == csg_pkg::ESC_STOP);
	assign emits    = !esc || (ent_j == csg_pkg::ESC_LIFT) || (ent_j == csg_pkg::ESC_REPEAT);
	assign out_free = !out_valid_q || out_ready;
	assign go       = (state_q == ST_WALK) && (!emits || out_free);
	assign idle     = (state_q == ST_IDLE);

	// Grid point of the current entry
	assign iw     = (WW+4)'(ent_i) * (WW+4)'(w_q);
	assign jw     = (WW+4)'(ent_j) * (WW+4)'(w_q);
	assign grid_s = to_out(s0_q + $signed({{(AccW-WW-4){1'b0}}, iw}));
	assign grid_t = to_out(t0_q + $signed({{(AccW-WW-4){1'b0}}, jw}));
	assign d10    = $signed({{(AccW-WW-3){1'b0}}, w10_q});

	// Origin at grid (0,0) with the pen at grid (2,2)
	assign s0_init = $signed({{(AccW-csg_pkg::CoordW-2){job.pen_s[csg_pkg::CoordW-1]}},
	                          job.pen_s, 2'b00}) -
	                 $signed({{(AccW-WW-1){1'b0}}, job.width, 1'b0});
	assign t0_init = $signed({{(AccW-csg_pkg::CoordW-2){job.pen_t[csg_pkg::CoordW-1]}},
	                          job.pen_t, 2'b00}) -
	                 $signed({{(AccW-WW-1){1'b0}}, job.width, 1'b0});

	// Entry decode, next state and result selection
	always_comb begin
		state_d = state_q;
		s0_d    = s0_q;
		t0_d    = t0_q;
		load    = 1'b0;
		kind_d  = csg_pkg::KIND_POINT;
		ps_d    = grid_s;
		pt_d    = grid_t;
		rom_req.en   = 1'b0;
		rom_req.addr = {sym_q, k_q + 1'b1};
		unique case (state_q)
			ST_IDLE: begin
				rom_req.addr = {job.sym, {csg_pkg::EntryW{1'b0}}};
				if (start) begin
					rom_req.en = 1'b1;
					state_d    = ST_WALK;
				end
			end
			ST_WALK: begin
				if (go) begin
					load = emits;
					if (esc) begin
						ps_d = '0;
						pt_d = '0;
						case (ent_j)
							csg_pkg::ESC_LIFT:   kind_d = csg_pkg::KIND_LIFT;
							csg_pkg::ESC_REPEAT: begin
								ps_d = last_s_q;
								pt_d = last_t_q;
							end
							csg_pkg::ESC_T_UP:   t0_d = t0_q + d10;
							csg_pkg::ESC_T_DOWN: t0_d = t0_q - d10;
							csg_pkg::ESC_S_UP:   s0_d = s0_q + d10;
							csg_pkg::ESC_S_DOWN: s0_d = s0_q - d10;
							default: ;
						endcase
					end
					if (stop || (&k_q)) begin
						state_d = ST_FINAL;
					end else begin
						rom_req.en = 1'b1;
					end
				end
			end
			ST_FINAL: begin
				kind_d = csg_pkg::KIND_MOVE;
				ps_d   = to_out(s0_q + $signed({{(AccW-WW-1){1'b0}}, w_q, 1'b0}));
				pt_d   = to_out(t0_q + $signed({{(AccW-WW-1){1'b0}}, w_q, 1'b0}));
				if (out_free) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Job and walk registers
	always_ff @(posedge clk) begin
		if (idle && start) begin
			sym_q    <= job.sym;
			k_q      <= '0;
			w_q      <= job.width;
			w10_q    <= {job.width, 3'b000} + {2'b00, job.width, 1'b0};
			s0_q     <= s0_init;
			t0_q     <= t0_init;
			last_s_q <= job.pen_s;
			last_t_q <= job.pen_t;
		end else if (go) begin
			k_q  <= k_q + 1'b1;
			s0_q <= s0_d;
			t0_q <= t0_d;
			if (!esc) begin
				last_s_q <= grid_s;
				last_t_q <= grid_t;
			end
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= kind_d;
			ps_q   <= ps_d;
			pt_q   <= pt_d;
			last_q <= (state_q == ST_FINAL);
		end
	end

	assign out_valid  = out_valid_q;
	assign event_kind = kind_q;
	assign point_s    = ps_q;
	assign point_t    = pt_q;
	assign last_event = last_q;

`ifndef SYNTHESIS
	a_start_walk: assert property (@(posedge clk) disable iff (!arst_n)
		idle && start |=> (state_q == ST_WALK) && (k_q == '0))
		else $error("walk did not begin at entry zero");

	a_final_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINAL) && out_free |=>
			out_valid_q && last_q && (kind_q == csg_pkg::KIND_MOVE) && idle)
		else $error("final move not delivered");

	a_lift_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (kind_q == csg_pkg::KIND_LIFT) |->
			!last_q && (ps_q == '0) && (pt_q == '0))
		else $error("pen lift carries coordinates");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) && rom_req.en |-> !(&k_q))
		else $error("read past end of stroke program");

	a_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> out_free)
		else $error("pending result overwritten");
`endif

endmodule

### hdl/centered_marker_stroke_generator.sv
// ----------------------------------------------------------------------------
// centered_marker_stroke_generator: marker symbol to stroke point stream
// Window registers, symbol number reduction and the walk over the stroke ROM.
// ----------------------------------------------------------------------------
// Each request draws one marker centered on the pen. A pen outside the
// window is dropped in the cycle it is accepted and gives no results.
// Otherwise the symbol's program is read from a synchronous stroke ROM, one
// entry per cycle while the output does not stall, walking up to 16
// entries for at most 17 results. The next request is taken once the final
// move sits in the output register. Configuration writes are always taken.
module centered_marker_stroke_generator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [15:0]                  symbol_number,
	input  logic [csg_pkg::WidthW-1:0]          marker_width,
	input  logic signed [csg_pkg::CoordW-1:0]   pen_s,
	input  logic signed [csg_pkg::CoordW-1:0]   pen_t,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          event_kind,
	output logic signed [csg_pkg::CoordW-1:0]   point_s,
	output logic signed [csg_pkg::CoordW-1:0]   point_t,
	output logic                                last_event,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [csg_pkg::CoordW-1:0]          cfg_data
);

	logic signed [csg_pkg::CoordW-1:0] s_low_q, s_high_q, t_low_q, t_high_q;
	logic                              in_window, idle, start;
	logic [3:0]                        num_low;
	csg_pkg::job_t                     job;
	csg_pkg::rom_req_t                 rom_req;
	logic [2*csg_pkg::EntryW-1:0]      rom_data;

	// Window registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_low_q  <= {1'b1, {(csg_pkg::CoordW-1){1'b0}}};
			s_high_q <= {1'b0, {(csg_pkg::CoordW-1){1'b1}}};
			t_low_q  <= {1'b1, {(csg_pkg::CoordW-1){1'b0}}};
			t_high_q <= {1'b0, {(csg_pkg::CoordW-1){1'b1}}};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				csg_pkg::CFG_S_LOW:  s_low_q  <= cfg_data;
				csg_pkg::CFG_S_HIGH: s_high_q <= cfg_data;
				csg_pkg::CFG_T_LOW:  t_low_q  <= cfg_data;
				csg_pkg::CFG_T_HIGH: t_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Window check
	assign in_window = (pen_s >= s_low_q) && (pen_s <= s_high_q) &&
	                   (pen_t >= t_low_q) && (pen_t <= t_high_q);

	// Program index: (|number| - 1) mod 16, only the low nibble matters
	assign num_low = symbol_number[15] ? (~symbol_number[3:0] + 4'd1) : symbol_number[3:0];

	assign job.sym   = num_low - 4'd1;
	assign job.width = marker_width;
	assign job.pen_s = pen_s;
	assign job.pen_t = pen_t;

	assign in_ready = idle;
	assign start    = in_valid && idle && in_window;

	csg_rom u_rom (
		.clk  (clk),
		.req  (rom_req),
		.data (rom_data)
	);

	csg_walker u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.job        (job),
		.idle       (idle),
		.rom_req    (rom_req),
		.rom_data   (rom_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_kind (event_kind),
		.point_s    (point_s),
		.point_t    (point_t),
		.last_event (last_event)
	);

endmodule
